>>> hw/rtl/sofi_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted offset floor index
// no dependencies; imported by every module of the block
package sofi_pkg;

  localparam int unsigned DEFAULT_DEPTH = 64;

  // request type
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DUP  = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_MISS = 2'd3;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_start;
    logic [31:0] found_id;
    logic [31:0] max_stored;
  } res_t;

endpackage

>>> hw/rtl/sorted_offset_floor_index_top.sv
`timescale 1ns / 1ps
// channel | handshake               | payload
// in      | in_valid_i / in_ready_o | req_type_i, query_offset_i, entry_id_i
// out     | out_valid_o / out_ready_i | status_o, found_start_o, found_id_o, max_stored_o
// a lookup scans from the top entry down, one memory read per cycle, and stops at
// the floor entry, or at the bottom entry on a miss; an insert scans the same way,
// then, unless it is a duplicate or the table is full, shifts the entries above the
// insert point up one per cycle. the single read port of the entry memory sets this pace
// reset empties the table at once (count cleared), no clearing pass
// a waiting result sits in the output register while the next request is worked on
// depends on sofi_pkg, sofi_mem, sofi_seq
module sorted_offset_floor_index_top import sofi_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] query_offset_i,
  input  logic [31:0] entry_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_start_o,
  output logic [31:0] found_id_o,
  output logic [31:0] max_stored_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          seq_idle;
  logic          seq_res_valid;
  res_t          seq_res;
  logic          res_take;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  logic out_valid_q, out_valid_d;
  res_t out_q;

  sofi_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  sofi_seq #(.DEPTH(DEPTH)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_valid_i && seq_idle),
    .req_type_i    (req_type_i),
    .query_offset_i(query_offset_i),
    .entry_id_i    (entry_id_i),
    .idle_o        (seq_idle),
    .res_valid_o   (seq_res_valid),
    .res_o         (seq_res),
    .res_take_i    (res_take),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data)
  );

  // output register frees the sequencer as soon as a result is handed over
  assign res_take = seq_res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= seq_res;
    end
  end

  assign in_ready_o    = seq_idle;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign found_start_o = out_q.found_start;
  assign found_id_o    = out_q.found_id;
  assign max_stored_o  = out_q.max_stored;

endmodule

>>> hw/rtl/sofi_mem.sv
`timescale 1ns / 1ps
// entry store: one write port, one read port with registered read data
// depends on sofi_pkg for the entry type
module sofi_mem import sofi_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/sofi_seq.sv
`timescale 1ns / 1ps
// sequencer: downward scan for the floor entry, then shift-up pass for inserts
// depends on sofi_pkg; drives the ports of sofi_mem
module sofi_seq import sofi_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          req_type_i,
  input  logic [31:0]   query_offset_i,
  input  logic [31:0]   entry_id_i,
  output logic          idle_o,
  output logic          res_valid_o,
  output res_t          res_o,
  input  logic          res_take_i,
  output logic          mem_rd_en_o,
  output logic [AW-1:0] mem_rd_addr_o,
  input  entry_t        mem_rd_data_i,
  output logic          mem_wr_en_o,
  output logic [AW-1:0] mem_wr_addr_o,
  output entry_t        mem_wr_data_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          type_q, type_d;
  logic [31:0]   key_q, key_d;
  logic [31:0]   id_q, id_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   max_q, max_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          vld_q, vld_d;
  logic [AW-1:0] pidx_q, pidx_d;
  status_t       status_q, status_d;
  logic [31:0]   fstart_q, fstart_d;
  logic [31:0]   fid_q, fid_d;

  logic cmp_le, cmp_eq;
  logic scan_end, scan_hit;

  // comparators on the read data; only the scan pass uses them
  assign cmp_le = (mem_rd_data_i.off <= key_q);
  assign cmp_eq = (mem_rd_data_i.off == key_q);

  always_comb begin
    state_d       = state_q;
    type_d        = type_q;
    key_d         = key_q;
    id_d          = id_q;
    count_d       = count_q;
    max_d         = max_q;
    scan_d        = scan_q;
    pos_d         = pos_q;
    vld_d         = vld_q;
    pidx_d        = pidx_q;
    status_d      = status_q;
    fstart_d      = fstart_q;
    fid_d         = fid_q;
    scan_end      = 1'b0;
    scan_hit      = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = AW'(scan_q - CW'(1));
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = pidx_q + AW'(1);
    mem_wr_data_o = mem_rd_data_i;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          type_d  = req_type_i;
          key_d   = query_offset_i;
          id_d    = entry_id_i;
          scan_d  = count_q;
          vld_d   = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (vld_q) begin
          if (cmp_le) begin
            scan_end = 1'b1;
            scan_hit = 1'b1;
          end else if (pidx_q == '0) begin
            scan_end = 1'b1;
          end
        end else if (scan_q == '0) begin
          scan_end = 1'b1;
        end

        if (!scan_end) begin
          if (scan_q != '0) begin
            mem_rd_en_o = 1'b1;
            scan_d      = scan_q - CW'(1);
            pidx_d      = AW'(scan_q - CW'(1));
            vld_d       = 1'b1;
          end else begin
            vld_d = 1'b0;
          end
        end else begin
          // any read still in flight is dropped
          vld_d    = 1'b0;
          fstart_d = '0;
          fid_d    = '0;
          if (type_q == REQ_LOOKUP) begin
            status_d = scan_hit ? ST_OK : ST_MISS;
            if (scan_hit) begin
              fstart_d = mem_rd_data_i.off;
              fid_d    = mem_rd_data_i.id;
            end
            state_d = S_DONE;
          end else if (scan_hit && cmp_eq) begin
            status_d = ST_DUP;
            state_d  = S_DONE;
          end else if (count_q == CW'(DEPTH)) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            pos_d   = scan_hit ? (CW'(pidx_q) + CW'(1)) : '0;
            scan_d  = count_q;
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // move entry k to k+1, from the top down to the insert position
        if (vld_q) begin
          mem_wr_en_o = 1'b1;
        end
        if (scan_q != pos_q) begin
          mem_rd_en_o = 1'b1;
          scan_d      = scan_q - CW'(1);
          pidx_d      = AW'(scan_q - CW'(1));
          vld_d       = 1'b1;
        end else begin
          vld_d = 1'b0;
          if (!vld_q) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_addr_o = AW'(pos_q);
            mem_wr_data_o = '{off: key_q, id: id_q};
            count_d       = count_q + CW'(1);
            if (count_q == '0 || key_q > max_q) begin
              max_d = key_q;
            end
            status_d = ST_OK;
            state_d  = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      max_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      max_q   <= max_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    key_q    <= key_d;
    id_q     <= id_d;
    scan_q   <= scan_d;
    pos_q    <= pos_d;
    pidx_q   <= pidx_d;
    status_q <= status_d;
    fstart_q <= fstart_d;
    fid_q    <= fid_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{status: status_q, found_start: fstart_q,
                         found_id: fid_q, max_stored: max_q};

endmodule

>>> hw/rtl/sofi_checker.sv
`timescale 1ns / 1ps
// port-level checks for the sorted offset floor index, bound to the top level
// depends on sofi_pkg for the status codes
module sofi_checker import sofi_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] found_start_o,
  input logic [31:0] found_id_o,
  input logic [31:0] max_stored_o
);

  // a request keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request was taken");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(found_start_o) && $stable(found_id_o) && $stable(max_stored_o))
    else $error("result changed while stalled");

  // only a successful lookup reports a found entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> found_start_o == '0 && found_id_o == '0)
    else $error("found fields set on a miss, duplicate or full result");

  // a floor entry is never above the largest stored offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> found_start_o <= max_stored_o)
    else $error("found offset above largest stored offset");

endmodule

bind sorted_offset_floor_index_top sofi_checker u_sofi_checker (.*);
